// ===== rtl/acuc_pkg.sv =====
package acuc_pkg;

    // Clock arithmetic constants
    localparam int HOURS_PER_DAY = 24;
    localparam int MINS_PER_HOUR = 60;
    localparam int DEC_BASE      = 10;

    // Timekeeper run commands
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // Input item as carried on the slave tdata, lowest bit last
    typedef struct packed {
        logic [5:0] cur_minutes;
        logic [4:0] cur_hours;
        logic       btn_alarm_active;
        logic       btn_minute;
        logic       btn_hour;
        logic       btn_set_alarm;
        logic       btn_set_time;
    } in_item_t;

    // Result item as carried on the master tdata, lowest bit last
    typedef struct packed {
        logic [1:0] pad;
        logic       alarm_enabled;
        logic [1:0] run_command;
        logic [5:0] new_minutes;
        logic [4:0] new_hours;
        logic       time_write;
        logic       alarm_indicator;
        logic       display_blank;
        logic [3:0] digit_minutes_ones;
        logic [2:0] digit_minutes_tens;
        logic [3:0] digit_hours_ones;
        logic [1:0] digit_hours_tens;
    } out_item_t;

    // Control results of one tick, before digit conversion
    typedef struct packed {
        logic [4:0] show_hours;
        logic [5:0] show_minutes;
        logic       blank;
        logic       indicator;
        logic       write;
        logic [4:0] new_hours;
        logic [5:0] new_minutes;
        logic [1:0] cmd;
    } ctrl_res_t;

    // Hour increment, wrapping to zero at the last hour or anything above
    function automatic logic [4:0] inc_hours(input logic [4:0] h);
        return (h >= 5'(HOURS_PER_DAY - 1)) ? 5'd0 : h + 5'd1;
    endfunction

    // Minute increment, wrapping to zero at the last minute or anything above
    function automatic logic [5:0] inc_minutes(input logic [5:0] m);
        return (m >= 6'(MINS_PER_HOUR - 1)) ? 6'd0 : m + 6'd1;
    endfunction

    // Split a value of up to 63 into tens (upper 3 bits) and ones (lower 4 bits)
    function automatic logic [6:0] bcd_split(input logic [5:0] v);
        logic [2:0] t;
        logic [5:0] r;
        if (v >= 6'(6 * DEC_BASE))
            t = 3'd6;
        else if (v >= 6'(5 * DEC_BASE))
            t = 3'd5;
        else if (v >= 6'(4 * DEC_BASE))
            t = 3'd4;
        else if (v >= 6'(3 * DEC_BASE))
            t = 3'd3;
        else if (v >= 6'(2 * DEC_BASE))
            t = 3'd2;
        else if (v >= 6'(DEC_BASE))
            t = 3'd1;
        else
            t = 3'd0;
        r = v - 6'({3'd0, t} * 6'(DEC_BASE));
        return {t, r[3:0]};
    endfunction

endpackage

// ===== rtl/alarm_clock_ui_controller_unit.sv =====
// Alarm clock front-panel controller. Each transfer on the slave stream is one polling
// tick carrying the button levels and the timekeeper's current hours and minutes; each
// tick gives exactly one result transfer with the four display digits, blank flag, alarm
// indicator, a time write request and a stop/start command. A tick is accepted whenever
// the result register is free or being emptied, so a sustained rate of one item per cycle
// is reached while the master side does not stall. The result is held in the single result
// register; a tick is taken while a result waits if the master takes it in the same cycle.
module alarm_clock_ui_controller_unit #(
    parameter int BLINK_TICKS = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] btn_set_time, [1] btn_set_alarm, [2] btn_hour, [3] btn_minute,
    // [4] btn_alarm_active, [9:5] cur_hours, [15:10] cur_minutes
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] digit_hours_tens, [5:2] digit_hours_ones, [8:6] digit_minutes_tens,
    // [12:9] digit_minutes_ones, [13] display_blank, [14] alarm_indicator,
    // [15] time_write, [20:16] new_hours, [26:21] new_minutes, [28:27] run_command,
    // [29] alarm_enabled, [31:30] zero
    output logic [31:0] m_axis_tdata
);
    import acuc_pkg::*;

    logic       accept;
    in_item_t   in_item;
    ctrl_res_t  ctrl_res;
    out_item_t  out_item;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg;

    // Take a tick whenever the result register is free or being emptied
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_item       = in_item_t'(s_axis_tdata);

    acuc_ctrl #(
        .BLINK_TICKS (BLINK_TICKS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_item),
        .res    (ctrl_res)
    );

    acuc_disp u_disp (
        .res  (ctrl_res),
        .item (out_item)
    );

    // Result register valid flag
    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Result payload, loaded on each accepted transfer
    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_item;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = 32'(out_data_reg);

endmodule

// ===== rtl/acuc_ctrl.sv =====
module acuc_ctrl #(
    parameter int BLINK_TICKS = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  acuc_pkg::in_item_t item,
    output acuc_pkg::ctrl_res_t res
);
    import acuc_pkg::*;

    localparam int CntW = $clog2(2 * BLINK_TICKS);
    localparam logic [CntW-1:0] HALF_CNT = CntW'(BLINK_TICKS);
    localparam logic [CntW-1:0] LAST_CNT = CntW'(2 * BLINK_TICKS - 1);

    // Mode codes
    localparam logic [1:0] MODE_POWER_ON  = 2'd0;
    localparam logic [1:0] MODE_SHOW      = 2'd1;
    localparam logic [1:0] MODE_SET_TIME  = 2'd2;
    localparam logic [1:0] MODE_SET_ALARM = 2'd3;

    logic [1:0]      mode_reg, mode_next;
    logic [CntW-1:0] blink_reg, blink_next;
    logic            allow_reg, allow_next;
    logic [4:0]      al_hours_reg, al_hours_next;
    logic [5:0]      al_minutes_reg, al_minutes_next;

    // Mode logic for one tick
    always_comb
    begin
        mode_next       = mode_reg;
        blink_next      = blink_reg;
        allow_next      = allow_reg;
        al_hours_next   = al_hours_reg;
        al_minutes_next = al_minutes_reg;
        res.show_hours   = item.cur_hours;
        res.show_minutes = item.cur_minutes;
        res.blank        = 1'b0;
        res.write        = 1'b0;
        res.new_hours    = item.cur_hours;
        res.new_minutes  = item.cur_minutes;
        res.cmd          = CMD_NONE;
        unique case (mode_reg)
            MODE_POWER_ON:
            begin
                if (item.btn_set_time)
                begin
                    mode_next  = MODE_SET_TIME;
                    blink_next = '0;
                end
                else
                begin
                    // Blank during the second half of each blink period.
                    res.blank  = (blink_reg >= HALF_CNT);
                    blink_next = (blink_reg == LAST_CNT) ? '0 : blink_reg + 1'b1;
                end
            end
            MODE_SHOW:
            begin
                allow_next = 1'b1;
                if (item.btn_set_time)
                begin
                    res.cmd   = CMD_STOP;
                    mode_next = MODE_SET_TIME;
                end
                else if (item.btn_set_alarm)
                    mode_next = MODE_SET_ALARM;
            end
            MODE_SET_TIME:
            begin
                allow_next = 1'b0;
                if (item.btn_set_time)
                begin
                    // The hour button wins over the minute button.
                    if (item.btn_hour)
                    begin
                        res.write     = 1'b1;
                        res.new_hours = inc_hours(item.cur_hours);
                    end
                    else if (item.btn_minute)
                    begin
                        res.write       = 1'b1;
                        res.new_minutes = inc_minutes(item.cur_minutes);
                    end
                end
                else
                begin
                    res.cmd   = CMD_START;
                    mode_next = MODE_SHOW;
                end
            end
            MODE_SET_ALARM:
            begin
                allow_next       = 1'b0;
                res.show_hours   = al_hours_reg;
                res.show_minutes = al_minutes_reg;
                if (item.btn_set_alarm)
                begin
                    if (item.btn_hour)
                        al_hours_next = inc_hours(al_hours_reg);
                    else if (item.btn_minute)
                        al_minutes_next = inc_minutes(al_minutes_reg);
                end
                else
                    mode_next = MODE_SHOW;
            end
        endcase
        res.indicator = allow_next & item.btn_alarm_active;
    end

    // State advances only on an accepted transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_POWER_ON;
            blink_reg      <= '0;
            allow_reg      <= 1'b0;
            al_hours_reg   <= '0;
            al_minutes_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            blink_reg      <= blink_next;
            allow_reg      <= allow_next;
            al_hours_reg   <= al_hours_next;
            al_minutes_reg <= al_minutes_next;
        end
    end

    // The blink counter only runs in power-on mode.
    a_blink_only_power_on: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_POWER_ON) |-> (blink_reg == '0))
        else $error("blink counter running outside power-on mode");

    a_blink_range: assert property (@(posedge clk) disable iff (!rst_n)
        blink_reg <= LAST_CNT)
        else $error("blink counter beyond its period");

    a_alarm_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        (al_hours_reg < 5'(HOURS_PER_DAY)) && (al_minutes_reg < 6'(MINS_PER_HOUR)))
        else $error("stored alarm time out of range");

    a_set_time_disallows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode_reg == MODE_SET_TIME)) |=> !allow_reg)
        else $error("alarm still allowed after a set-time tick");

endmodule

// ===== rtl/acuc_disp.sv =====
module acuc_disp (
    input  acuc_pkg::ctrl_res_t res,
    output acuc_pkg::out_item_t item
);
    import acuc_pkg::*;

    logic [6:0] hours_bcd;
    logic [6:0] minutes_bcd;

    // Decimal digits of the shown time, masked to the digit widths
    assign hours_bcd   = bcd_split({1'b0, res.show_hours});
    assign minutes_bcd = bcd_split(res.show_minutes);

    always_comb
    begin
        item.pad                = '0;
        item.digit_hours_tens   = hours_bcd[5:4];
        item.digit_hours_ones   = hours_bcd[3:0];
        item.digit_minutes_tens = minutes_bcd[6:4];
        item.digit_minutes_ones = minutes_bcd[3:0];
        item.display_blank      = res.blank;
        item.alarm_indicator    = res.indicator;
        item.time_write         = res.write;
        item.new_hours          = res.new_hours;
        item.new_minutes        = res.new_minutes;
        item.run_command        = res.cmd;
        item.alarm_enabled      = res.indicator;
    end

endmodule

// ===== tb/sv/tb_alarm_clock_ui_controller_unit.sv =====
`timescale 1ns / 100ps

module tb_alarm_clock_ui_controller_unit;

    import acuc_pkg::*;

    localparam int BLINK_TICKS   = 5;
    localparam int RANDOM_TICKS  = 1550;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int DRAIN_CYCLES  = 4;

    // Panel modes as the controller steps through them
    typedef enum logic [1:0] {
        PANEL_POWER_ON  = 2'd0,
        PANEL_SHOW      = 2'd1,
        PANEL_SET_TIME  = 2'd2,
        PANEL_SET_ALARM = 2'd3
    } panel_mode_e;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata   = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [31:0] m_axis_tdata;

    // Ticks waiting to be sent and panel results waiting to be seen
    in_item_t    tick_queue[$];
    out_item_t   panel_expected[$];

    // Own copy of the controller state
    panel_mode_e panel_mode;
    int          blink_cnt;
    logic        alarm_allow;
    logic [4:0]  alarm_hours;
    logic [5:0]  alarm_minutes;

    int          ticks_queued;
    int          ticks_taken;
    int          results_seen;
    int          err_count;
    int          cycle_count;
    int          send_gap;
    int          send_calm;
    int          stall_left;
    int          stall_calm;
    int          writes_seen;
    int          stops_seen;
    int          starts_seen;
    int          blanks_seen;
    int          alarm_mode_ticks;

    alarm_clock_ui_controller_unit #(
        .BLINK_TICKS (BLINK_TICKS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Hour and minute stepping as the set buttons do it, wrapping past the end of the range
    function automatic logic [4:0] step_hour(input logic [4:0] h);
        if (h >= 5'(HOURS_PER_DAY - 1))
            return 5'd0;
        return h + 5'd1;
    endfunction

    function automatic logic [5:0] step_minute(input logic [5:0] m);
        if (m >= 6'(MINS_PER_HOUR - 1))
            return 6'd0;
        return m + 6'd1;
    endfunction

    // Works out the panel result of one tick and advances the model state
    function automatic out_item_t panel_response(input in_item_t t);
        out_item_t   r;
        int          sh;
        int          sm;
        logic        blank;
        logic        wr;
        logic        ind;
        logic [4:0]  nh;
        logic [5:0]  nm;
        logic [1:0]  cmd;
        panel_mode_e nxt;
        sh    = t.cur_hours;
        sm    = t.cur_minutes;
        blank = 1'b0;
        wr    = 1'b0;
        nh    = t.cur_hours;
        nm    = t.cur_minutes;
        cmd   = CMD_NONE;
        nxt   = panel_mode;
        case (panel_mode)
            PANEL_POWER_ON:
            begin
                blank = ((blink_cnt / BLINK_TICKS) % 2) == 1;
                if (t.btn_set_time)
                begin
                    blank     = 1'b0;
                    nxt       = PANEL_SET_TIME;
                    blink_cnt = 0;
                end
                else
                begin
                    blink_cnt = (blink_cnt + 1) % (2 * BLINK_TICKS);
                end
            end
            PANEL_SHOW:
            begin
                alarm_allow = 1'b1;
                if (t.btn_set_time)
                begin
                    cmd = CMD_STOP;
                    nxt = PANEL_SET_TIME;
                end
                else if (t.btn_set_alarm)
                begin
                    nxt = PANEL_SET_ALARM;
                end
            end
            PANEL_SET_TIME:
            begin
                alarm_allow = 1'b0;
                if (t.btn_set_time)
                begin
                    // The hour button takes priority over the minute button.
                    if (t.btn_hour)
                    begin
                        wr = 1'b1;
                        nh = step_hour(t.cur_hours);
                    end
                    else if (t.btn_minute)
                    begin
                        wr = 1'b1;
                        nm = step_minute(t.cur_minutes);
                    end
                end
                else
                begin
                    cmd = CMD_START;
                    nxt = PANEL_SHOW;
                end
            end
            default:
            begin
                alarm_allow = 1'b0;
                sh = alarm_hours;
                sm = alarm_minutes;
                alarm_mode_ticks++;
                if (t.btn_set_alarm)
                begin
                    if (t.btn_hour)
                        alarm_hours = step_hour(alarm_hours);
                    else if (t.btn_minute)
                        alarm_minutes = step_minute(alarm_minutes);
                end
                else
                begin
                    nxt = PANEL_SHOW;
                end
            end
        endcase
        panel_mode = nxt;
        ind = alarm_allow & t.btn_alarm_active;

        // Digits come from the raw value and are cut to the digit widths.
        r.pad                = 2'd0;
        r.digit_hours_tens   = 2'(sh / DEC_BASE);
        r.digit_hours_ones   = 4'(sh % DEC_BASE);
        r.digit_minutes_tens = 3'(sm / DEC_BASE);
        r.digit_minutes_ones = 4'(sm % DEC_BASE);
        r.display_blank      = blank;
        r.alarm_indicator    = ind;
        r.time_write         = wr;
        r.new_hours          = nh;
        r.new_minutes        = nm;
        r.run_command        = cmd;
        r.alarm_enabled      = ind;

        writes_seen += int'(wr);
        blanks_seen += int'(blank);
        if (cmd == CMD_STOP)
            stops_seen++;
        if (cmd == CMD_START)
            starts_seen++;
        return r;
    endfunction

    // Idle length for either side: mostly none or short, now and then long, with calm stretches
    function automatic int next_idle(inout int calm);
        int pick;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 59) == 0)
        begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 2);
        if (pick < 96)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    // Time values: mostly legal, often at the wrap point, sometimes beyond the legal range
    function automatic int rand_hours();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return $urandom_range(0, 23);
        if (pick < 85)
            return $urandom_range(22, 23);
        return $urandom_range(0, 31);
    endfunction

    function automatic int rand_minutes();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return $urandom_range(0, 59);
        if (pick < 85)
            return $urandom_range(58, 59);
        return $urandom_range(0, 63);
    endfunction

    task automatic add_tick(input int st, input int sa, input int hb, input int mb,
                            input int sw, input int h, input int m);
        in_item_t t;
        t.btn_set_time     = 1'(st);
        t.btn_set_alarm    = 1'(sa);
        t.btn_hour         = 1'(hb);
        t.btn_minute       = 1'(mb);
        t.btn_alarm_active = 1'(sw);
        t.cur_hours        = 5'(h);
        t.cur_minutes      = 6'(m);
        tick_queue.push_back(t);
        ticks_queued++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: result %0d field %s: expected %0d, got %0d",
                     $time, results_seen, name, exp_v, act_v);
            err_count++;
        end
    endtask

    // Driver: presents queued ticks on the slave side, with random gaps between transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (tick_queue.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= tick_queue.pop_front();
                send_gap = next_idle(send_calm);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: predicts each accepted tick, checks each result transfer and stalls the master side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (panel_expected.size() == 0)
                begin
                    $display("%0t: unexpected result, expected nothing, got %h",
                             $time, m_axis_tdata);
                    err_count++;
                end
                else
                begin
                    out_item_t e;
                    out_item_t a;
                    e = panel_expected.pop_front();
                    a = m_axis_tdata;
                    compare_field("digit_hours_tens", e.digit_hours_tens, a.digit_hours_tens);
                    compare_field("digit_hours_ones", e.digit_hours_ones, a.digit_hours_ones);
                    compare_field("digit_minutes_tens", e.digit_minutes_tens,
                                  a.digit_minutes_tens);
                    compare_field("digit_minutes_ones", e.digit_minutes_ones,
                                  a.digit_minutes_ones);
                    compare_field("display_blank", e.display_blank, a.display_blank);
                    compare_field("alarm_indicator", e.alarm_indicator, a.alarm_indicator);
                    compare_field("time_write", e.time_write, a.time_write);
                    compare_field("new_hours", e.new_hours, a.new_hours);
                    compare_field("new_minutes", e.new_minutes, a.new_minutes);
                    compare_field("run_command", e.run_command, a.run_command);
                    compare_field("alarm_enabled", e.alarm_enabled, a.alarm_enabled);
                    compare_field("pad", e.pad, a.pad);
                end
                results_seen++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                panel_expected.push_back(panel_response(s_axis_tdata));
                ticks_taken++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = next_idle(stall_calm);
            end
        end
    end

    // Cycle limit in case the block stops responding
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timed out after %0d cycles, %0d of %0d ticks taken, %0d results pending",
                     cycle_count, ticks_taken, ticks_queued, panel_expected.size());
            $display("** alarm_clock_ui_controller_unit: FAILED **");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int pick;
        int len;
        int i;
        panel_mode       = PANEL_POWER_ON;
        blink_cnt        = 0;
        alarm_allow      = 1'b0;
        alarm_hours      = '0;
        alarm_minutes    = '0;
        ticks_queued     = 0;
        ticks_taken      = 0;
        results_seen     = 0;
        err_count        = 0;
        cycle_count      = 0;
        send_gap         = 0;
        send_calm        = 0;
        stall_left       = 0;
        stall_calm       = 0;
        writes_seen      = 0;
        stops_seen       = 0;
        starts_seen      = 0;
        blanks_seen      = 0;
        alarm_mode_ticks = 0;

        // Power-on blinking through a full period, then set-time pressed during a dark phase
        for (i = 0; i < 15; i++)
            add_tick(0, i % 2, int'(i % 3 == 0), int'(i % 3 == 1), i % 2,
                     (i * 7) % 32, (i * 13) % 64);
        add_tick(0, 0, 0, 0, 1, 31, 63);
        add_tick(1, 0, 0, 0, 1, 23, 59);
        // Set time: hour wraps, minute wraps, hour wins over minute on a raw value
        add_tick(1, 0, 1, 0, 1, 23, 0);
        add_tick(1, 0, 0, 1, 0, 0, 59);
        add_tick(1, 1, 1, 1, 1, 31, 63);
        // Release starts the clock, then a fresh stop and start
        add_tick(0, 0, 0, 0, 1, 12, 34);
        add_tick(0, 0, 0, 0, 1, 0, 0);
        add_tick(1, 1, 0, 0, 1, 9, 9);
        add_tick(0, 0, 0, 0, 0, 10, 10);
        // Set alarm: hour and minute steps on the stored alarm time, then release
        add_tick(0, 1, 0, 0, 1, 20, 20);
        add_tick(1, 1, 1, 1, 1, 5, 5);
        add_tick(0, 1, 0, 1, 0, 6, 6);
        add_tick(0, 0, 0, 0, 1, 7, 7);

        // Random part: mostly complete set sessions, the rest idle showing and noise
        while (ticks_queued < 27 + RANDOM_TICKS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                add_tick(1, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 1), rand_hours(), rand_minutes());
                len = $urandom_range(1, 8);
                repeat (len)
                    add_tick(1, $urandom_range(0, 1), $urandom_range(0, 1),
                             $urandom_range(0, 1), $urandom_range(0, 1),
                             rand_hours(), rand_minutes());
                add_tick(0, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 1), rand_hours(), rand_minutes());
            end
            else if (pick < 70)
            begin
                add_tick(0, 1, $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 1), rand_hours(), rand_minutes());
                len = $urandom_range(1, 24);
                repeat (len)
                    add_tick($urandom_range(0, 1), 1, int'($urandom_range(0, 2) == 0),
                             $urandom_range(0, 1), $urandom_range(0, 1),
                             rand_hours(), rand_minutes());
                add_tick($urandom_range(0, 1), 0, $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 1), rand_hours(), rand_minutes());
            end
            else if (pick < 85)
            begin
                len = $urandom_range(1, 4);
                repeat (len)
                    add_tick(0, 0, $urandom_range(0, 1), $urandom_range(0, 1),
                             $urandom_range(0, 1), rand_hours(), rand_minutes());
            end
            else
            begin
                len = $urandom_range(1, 5);
                repeat (len)
                    add_tick($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                             $urandom_range(0, 1), $urandom_range(0, 1),
                             $urandom_range(0, 31), $urandom_range(0, 63));
            end
        end

        // Reset is released away from the active edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (ticks_taken < ticks_queued || panel_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d ticks and checked %0d results in %0d cycles.",
                 ticks_taken, results_seen, cycle_count);
        $display("Seen %0d time writes, %0d stops, %0d starts, %0d blanked, %0d set-alarm ticks.",
                 writes_seen, stops_seen, starts_seen, blanks_seen, alarm_mode_ticks);
        if (err_count == 0)
            $display("** alarm_clock_ui_controller_unit: PASSED **");
        else
            $display("** alarm_clock_ui_controller_unit: FAILED **");
        $finish;
    end

endmodule

// ===== alarm_clock_ui_controller_unit.f =====
rtl/acuc_pkg.sv
rtl/acuc_ctrl.sv
rtl/acuc_disp.sv
rtl/alarm_clock_ui_controller_unit.sv
tb/sv/tb_alarm_clock_ui_controller_unit.sv
